// ===== hdl/fte_pkg.sv =====
// Shared types and constants for the fan tach speed and duty estimator.
// Used by fte_div and fan_tach_rpm_and_duty_estimator_core; no dependencies.
package fte_pkg;

	localparam int MAX_FANS = 6;
	localparam int FAN_W    = 3;
	localparam int CFG_W    = 3;
	localparam int TACH_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int RPM_W    = 14;

	// Shared restoring divider: one quotient bit per cycle.
	localparam int DIV_NUM_W = 22;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam logic [CFG_W-1:0]     ACTIVE_FANS_RST = CFG_W'(6);
	localparam logic [CFG_W-1:0]     MAX_FANS_CODE   = CFG_W'(MAX_FANS);
	localparam logic [TACH_W-1:0]    TACH_MIN_EXCL   = 16'h003f;
	localparam logic [TACH_W-1:0]    TACH_MAX_EXCL   = 16'hffff;
	localparam logic [DIV_NUM_W-1:0] RPM_NUMERATOR   = 22'd675000;
	localparam logic [RPM_W-1:0]     RPM_LIVE_MIN    = 14'd100;
	localparam logic [RPM_W-1:0]     PEAK_LIVE_MIN   = 14'd200;
	localparam logic [BYTE_W-1:0]    DUTY_FULL       = 8'd255;
	localparam int                   AUTO_BIT        = 7;

	typedef struct packed {
		logic [FAN_W-1:0]  fan_index;
		logic [TACH_W-1:0] tach_count;
		logic [BYTE_W-1:0] mode_byte;
		logic [BYTE_W-1:0] duty_byte;
	} sample_t;

	typedef struct packed {
		logic [RPM_W-1:0]  fan_rpm;
		logic [BYTE_W-1:0] duty_estimate;
		logic              auto_mode;
		logic [RPM_W-1:0]  peak_speed;
		logic              index_ok;
	} result_t;

endpackage

// ===== hdl/fte_div.sv =====
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on fte_pkg for widths.
module fte_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fte_pkg::DIV_NUM_W-1:0]  dividend,
	input  logic [fte_pkg::DIV_DEN_W-1:0]  divisor,
	output logic                           done,
	output logic [fte_pkg::DIV_NUM_W-1:0]  quotient
);
	import fte_pkg::*;

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;
	logic [DIV_DEN_W:0]   diff;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/fan_tach_rpm_and_duty_estimator_core.sv =====
// Top level of the fan tach speed and duty estimator.
// Depends on fte_pkg and fte_div.
//
// Takes one fan sample word at a time and returns one result word per
// sample. The speed is 675000 / tach_count (0 for counts of 63 or less
// or of 65535), the per-fan peak store keeps the highest speed and is
// cleared by reset, and when the duty byte reads 0 on a spinning fan the
// duty is estimated as speed * 255 / peak. Both divisions run on one
// shared restoring divider that produces one quotient bit per clock over
// 22 steps. A live sample passes through S_RPM, S_PEAK, S_DUTY if the duty
// estimate runs, and S_DONE, where the result word is loaded; a rejected
// fan index goes straight to S_DONE and an out-of-range count via S_PEAK.
// The input stalls from accept until the result word is loaded, and the
// next sample can be taken on the following cycle, so a result word that
// still waits in the output register does not block the input. A further
// sample that finishes while that word is still stalled holds in S_DONE
// until the output register frees up. The active_fans register is to be
// written through the cfg port only while the block is idle, which the
// block does not enforce; cfg_ready is always high. Indices at or above
// min(active_fans, 6) keep the peak store and return an all-zero word.
module fan_tach_rpm_and_duty_estimator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fte_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  fte_pkg::sample_t           sample,
	output logic                       result_valid,
	input  logic                       result_stall,
	output fte_pkg::result_t           result
);
	import fte_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RPM  = 5'b00010,
		S_PEAK = 5'b00100,
		S_DUTY = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]  active_fans_q;
	logic [RPM_W-1:0]  peak_store_q [MAX_FANS];
	sample_t           smp_q;
	logic              ok_q;
	logic [RPM_W-1:0]  rpm_q;
	logic [RPM_W-1:0]  peak_q;
	logic [BYTE_W-1:0] duty_q;
	result_t           result_q;
	logic              result_valid_q;

	logic [CFG_W-1:0]     fan_limit;
	logic                 idx_ok;
	logic                 count_live;
	logic                 accept;
	logic                 out_free;
	logic [RPM_W-1:0]     peak_next;
	logic                 want_est;
	logic [DIV_NUM_W-1:0] rpm_x255;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_dividend;
	logic [DIV_DEN_W-1:0] div_divisor;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quotient;

	// Configuration: a single register, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_fans_q <= ACTIVE_FANS_RST;
		end else if (cfg_valid) begin
			active_fans_q <= cfg_data;
		end
	end

	// Input side: take a sample only in idle.
	assign sample_stall = (state_q != S_IDLE);
	assign accept       = sample_valid && !sample_stall;

	// Cap the fan count at the store depth, then range-check the index.
	assign fan_limit  = (active_fans_q < MAX_FANS_CODE) ? active_fans_q : MAX_FANS_CODE;
	assign idx_ok     = sample.fan_index < fan_limit;
	assign count_live = (sample.tach_count > TACH_MIN_EXCL) &&
	                    (sample.tach_count < TACH_MAX_EXCL);

	// Peak update and estimate decision, evaluated once the speed is known.
	assign peak_next = (rpm_q > peak_store_q[smp_q.fan_index]) ?
	                   rpm_q : peak_store_q[smp_q.fan_index];
	assign want_est  = (smp_q.duty_byte == '0) && (rpm_q > RPM_LIVE_MIN) &&
	                   (peak_next > PEAK_LIVE_MIN);
	// rpm * 255 as a shift and subtract.
	assign rpm_x255  = {rpm_q, {BYTE_W{1'b0}}} - DIV_NUM_W'(rpm_q);

	// Drive the shared divider: speed first, then the optional duty estimate.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = RPM_NUMERATOR;
		div_divisor  = sample.tach_count;
		unique case (state_q)
			S_IDLE: begin
				div_start = accept && idx_ok && count_live;
			end
			S_PEAK: begin
				div_start    = want_est;
				div_dividend = rpm_x255;
				div_divisor  = DIV_DEN_W'(peak_next);
			end
			S_RPM, S_DUTY, S_DONE: begin
				div_start = 1'b0;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	fte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Output register frees up when empty or when the word is taken.
	assign out_free = !result_valid_q || !result_stall;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < MAX_FANS; i++) begin
				peak_store_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!idx_ok) begin
							state_q <= S_DONE;
						end else if (count_live) begin
							state_q <= S_RPM;
						end else begin
							state_q <= S_PEAK;
						end
					end
				end
				S_RPM: begin
					if (div_done) begin
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					peak_store_q[smp_q.fan_index] <= peak_next;
					state_q <= want_est ? S_DUTY : S_DONE;
				end
				S_DUTY: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers for the sample in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample;
			ok_q  <= idx_ok;
			rpm_q <= '0;
		end
		if (state_q == S_RPM && div_done) begin
			rpm_q <= div_quotient[RPM_W-1:0];
		end
		if (state_q == S_PEAK) begin
			peak_q <= peak_next;
			duty_q <= smp_q.duty_byte;
		end
		if (state_q == S_DUTY && div_done) begin
			// Saturate the estimate at full duty.
			duty_q <= (div_quotient[DIV_NUM_W-1:BYTE_W] != '0) ?
			          DUTY_FULL : div_quotient[BYTE_W-1:0];
		end
	end

	// Output register: load in S_DONE, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			if (ok_q) begin
				result_q.fan_rpm       <= rpm_q;
				result_q.duty_estimate <= duty_q;
				result_q.auto_mode     <= smp_q.mode_byte[AUTO_BIT];
				result_q.peak_speed    <= peak_q;
				result_q.index_ok      <= 1'b1;
			end else begin
				result_q <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
